### hw/rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int DATA_W  = 8;
	localparam int KIND_W  = 2;
	localparam int TYPE_W  = 3;
	localparam int COUNT_W = 11;
	localparam int ERR_W   = 3;

	// Line bytes
	localparam logic [DATA_W-1:0] FLAG_BYTE     = 8'h7e;
	localparam logic [DATA_W-1:0] ESC_BYTE      = 8'h7d;
	localparam logic [DATA_W-1:0] ESC_FLAG_BYTE = 8'h5e;
	localparam logic [DATA_W-1:0] ESC_ESC_BYTE  = 8'h5d;

	// Address and control bytes
	localparam logic [DATA_W-1:0] ADDR_CMD   = 8'h03;
	localparam logic [DATA_W-1:0] ADDR_RSP   = 8'h01;
	localparam logic [DATA_W-1:0] CTL_INFO_0 = 8'h00;
	localparam logic [DATA_W-1:0] CTL_INFO_1 = 8'h40;
	localparam logic [DATA_W-1:0] CTL_SET    = 8'h03;
	localparam logic [DATA_W-1:0] CTL_DISC   = 8'h0b;
	localparam logic [DATA_W-1:0] CTL_UA     = 8'h07;
	localparam logic [DATA_W-1:0] CTL_RR_0   = 8'h05;
	localparam logic [DATA_W-1:0] CTL_RR_1   = 8'h85;
	localparam logic [DATA_W-1:0] CTL_REJ_0  = 8'h01;
	localparam logic [DATA_W-1:0] CTL_REJ_1  = 8'h81;

	// Result kinds
	localparam logic [KIND_W-1:0] K_DATA   = 2'd0;
	localparam logic [KIND_W-1:0] K_ACCEPT = 2'd1;
	localparam logic [KIND_W-1:0] K_REJECT = 2'd2;

	// Frame types
	localparam logic [TYPE_W-1:0] T_INFO = 3'd0;
	localparam logic [TYPE_W-1:0] T_SET  = 3'd1;
	localparam logic [TYPE_W-1:0] T_DISC = 3'd2;
	localparam logic [TYPE_W-1:0] T_UA   = 3'd3;
	localparam logic [TYPE_W-1:0] T_RR   = 3'd4;
	localparam logic [TYPE_W-1:0] T_REJ  = 3'd5;
	localparam logic [TYPE_W-1:0] T_NONE = 3'd7;

	// Error codes
	localparam logic [ERR_W-1:0] E_NONE     = 3'd0;
	localparam logic [ERR_W-1:0] E_CHECK    = 3'd1;
	localparam logic [ERR_W-1:0] E_EMPTY    = 3'd2;
	localparam logic [ERR_W-1:0] E_OVERFLOW = 3'd3;
	localparam logic [ERR_W-1:0] E_ESCAPE   = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [DATA_W-1:0]  data_byte;
		logic [TYPE_W-1:0]  frame_type;
		logic               sequence_bit;
		logic [COUNT_W-1:0] payload_count;
		logic [ERR_W-1:0]   error_code;
	} result_t;

endpackage

### hw/rtl/sfr_if.sv
interface sfr_byte_if;
	logic                      valid;
	logic                      ready;
	logic [sfr_pkg::DATA_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
	logic                       valid;
	logic                       ready;
	logic [sfr_pkg::KIND_W-1:0]  kind;
	logic [sfr_pkg::DATA_W-1:0]  data_byte;
	logic [sfr_pkg::TYPE_W-1:0]  frame_type;
	logic                       sequence_bit;
	logic [sfr_pkg::COUNT_W-1:0] payload_count;
	logic [sfr_pkg::ERR_W-1:0]   error_code;

	modport source (output valid, output kind, output data_byte, output frame_type,
		output sequence_bit, output payload_count, output error_code, input ready);
	modport sink (input valid, input kind, input data_byte, input frame_type,
		input sequence_bit, input payload_count, input error_code, output ready);
endinterface

### hw/rtl/stuffed_frame_receiver.sv
// Channel   Dir  Payload                                      Handshake
// line      in   rx_byte[7:0]                                 valid/ready
// result    out  kind, data_byte, frame_type, sequence_bit,   valid/ready
//                payload_count, error_code
// cfg       in   cfg_wdata (role_is_receiver)                 cfg_we
//
// One line byte per cycle when the result side is ready. A byte is taken into
// the input register and worked on there, its result (if any) landing in the
// output register. The output register sets the rate: a byte moves on only
// when the output register is empty or being emptied in the same cycle.
// Reset puts the receiver in hunt for an opening flag, role set to receiver.
module stuffed_frame_receiver #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	sfr_byte_if.sink     line,
	sfr_result_if.source result
);
	import sfr_pkg::*;

	logic              role_q;
	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              advance;
	logic              eng_valid;
	result_t           eng_res;
	logic              out_valid_q;
	result_t           out_q;

	assign advance = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= 1'b1;
		end else if (cfg_we) begin
			role_q <= cfg_wdata;
		end
	end

	sfr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.line     (line),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfr_engine #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1 && advance),
		.rx_byte          (byte_s1),
		.role_is_receiver (role_q),
		.res_valid        (eng_valid),
		.res              (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && eng_valid) begin
			out_q <= eng_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_q.kind;
	assign result.data_byte     = out_q.data_byte;
	assign result.frame_type    = out_q.frame_type;
	assign result.sequence_bit  = out_q.sequence_bit;
	assign result.payload_count = out_q.payload_count;
	assign result.error_code    = out_q.error_code;

	// A held result must never be overwritten by a byte moving on.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !advance)
		else $error("byte advanced over a stalled result");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.kind == K_DATA || out_q.kind == K_ACCEPT ||
			out_q.kind == K_REJECT))
		else $error("result kind out of range");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == K_DATA |->
			out_q.frame_type == T_INFO && out_q.error_code == E_NONE &&
			out_q.payload_count != '0)
		else $error("payload beat with bad side fields");

	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != K_DATA |-> out_q.data_byte == '0 &&
			((out_q.kind == K_ACCEPT) == (out_q.error_code == E_NONE)))
		else $error("frame report with inconsistent error code");

endmodule

### hw/rtl/sfr_in_reg.sv
module sfr_in_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	sfr_byte_if.sink                   line,
	input  logic                       advance,
	output logic                       valid_s1,
	output logic [sfr_pkg::DATA_W-1:0] byte_s1
);
	import sfr_pkg::*;

	logic accept;

	// The stage takes a new beat when empty or when its byte moves on this cycle.
	assign line.ready = !valid_s1 || advance;
	assign accept     = line.valid && line.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= line.rx_byte;
		end
	end

endmodule

### hw/rtl/sfr_engine.sv
module sfr_engine #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [sfr_pkg::DATA_W-1:0] rx_byte,
	input  logic                       role_is_receiver,
	output logic                       res_valid,
	output sfr_pkg::result_t           res
);
	import sfr_pkg::*;

	localparam int CNT_W   = $clog2(MAX_PAYLOAD + 1);
	localparam int CNT_X_W = CNT_W + COUNT_W;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_CLOSE  = 4'b0100,
		PH_INFO   = 4'b1000
	} phase_t;

	function automatic logic [TYPE_W-1:0] classify(input logic rx_role,
		input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] c);
		logic [TYPE_W-1:0] t;
		t = T_NONE;
		if (rx_role) begin
			if (a == ADDR_CMD) begin
				if (c == CTL_INFO_0 || c == CTL_INFO_1) t = T_INFO;
				else if (c == CTL_SET) t = T_SET;
				else if (c == CTL_DISC) t = T_DISC;
			end else if (a == ADDR_RSP) begin
				if (c == CTL_UA) t = T_UA;
			end
		end else begin
			if (a == ADDR_CMD) begin
				if (c == CTL_UA) t = T_UA;
				else if (c == CTL_REJ_0 || c == CTL_REJ_1) t = T_REJ;
				else if (c == CTL_RR_0 || c == CTL_RR_1) t = T_RR;
			end else if (a == ADDR_RSP) begin
				if (c == CTL_DISC) t = T_DISC;
			end
		end
		return t;
	endfunction

	phase_t              phase_q, phase_d;
	logic [DATA_W-1:0]   hdr_q [2];
	logic [1:0]          hdr_idx_q, hdr_idx_d;
	logic                hdr_we;
	logic                esc_q, esc_d;
	logic                held_valid_q, held_valid_d;
	logic [DATA_W-1:0]   held_q;
	logic                held_we;
	logic [DATA_W-1:0]   xor_q, xor_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [TYPE_W-1:0]   type_q, type_d;
	logic                seq_q, seq_d;

	logic                is_flag;
	logic [TYPE_W-1:0]   hdr_type;
	logic                have_d;
	logic [DATA_W-1:0]   dval;
	logic [CNT_W-1:0]    count_inc;
	logic [CNT_X_W-1:0]  count_x, count_inc_x;

	assign is_flag     = (rx_byte == FLAG_BYTE);
	assign hdr_type    = classify(role_is_receiver, hdr_q[0], hdr_q[1]);
	assign count_inc   = count_q + CNT_W'(1);
	assign count_x     = {{COUNT_W{1'b0}}, count_q};
	assign count_inc_x = {{COUNT_W{1'b0}}, count_inc};

	always_comb begin
		phase_d      = phase_q;
		hdr_idx_d    = hdr_idx_q;
		hdr_we       = 1'b0;
		esc_d        = esc_q;
		held_valid_d = held_valid_q;
		held_we      = 1'b0;
		xor_d        = xor_q;
		count_d      = count_q;
		type_d       = type_q;
		seq_d        = seq_q;
		have_d       = 1'b0;
		dval         = rx_byte;
		res_valid    = 1'b0;
		res          = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (is_flag) begin
					phase_d   = PH_HEADER;
					hdr_idx_d = 2'd0;
				end
			end
			PH_HEADER: begin
				if (is_flag) begin
					hdr_idx_d = 2'd0;
				end else if (!hdr_idx_q[1]) begin
					hdr_we    = 1'b1;
					hdr_idx_d = hdr_idx_q + 2'd1;
				end else begin
					hdr_idx_d = 2'd0;
					if (rx_byte != (hdr_q[0] ^ hdr_q[1]) || hdr_type == T_NONE) begin
						phase_d = PH_HUNT;
					end else begin
						type_d = hdr_type;
						if (hdr_type == T_INFO) seq_d = hdr_q[1][6];
						else if (hdr_type == T_RR || hdr_type == T_REJ) seq_d = hdr_q[1][7];
						else seq_d = 1'b0;
						if (hdr_type == T_INFO) begin
							phase_d      = PH_INFO;
							esc_d        = 1'b0;
							held_valid_d = 1'b0;
							xor_d        = '0;
							count_d      = '0;
						end else begin
							phase_d = PH_CLOSE;
						end
					end
				end
			end
			PH_CLOSE: begin
				phase_d = PH_HUNT;
				if (is_flag) begin
					res_valid        = 1'b1;
					res.kind         = K_ACCEPT;
					res.frame_type   = type_q;
					res.sequence_bit = seq_q;
				end
			end
			PH_INFO: begin
				// Rejects share the frame's sequence bit and the count so far.
				res.frame_type    = T_INFO;
				res.sequence_bit  = seq_q;
				res.payload_count = count_x[COUNT_W-1:0];
				if (is_flag) begin
					phase_d   = PH_HUNT;
					res_valid = 1'b1;
					if (esc_q) begin
						res.kind       = K_REJECT;
						res.error_code = E_ESCAPE;
					end else if (count_q == '0) begin
						res.kind       = K_REJECT;
						res.error_code = E_EMPTY;
					end else if (!held_valid_q || held_q != xor_q) begin
						res.kind       = K_REJECT;
						res.error_code = E_CHECK;
					end else begin
						res.kind = K_ACCEPT;
					end
				end else if (esc_q) begin
					esc_d = 1'b0;
					if (rx_byte == ESC_FLAG_BYTE) begin
						have_d = 1'b1;
						dval   = FLAG_BYTE;
					end else if (rx_byte == ESC_ESC_BYTE) begin
						have_d = 1'b1;
						dval   = ESC_BYTE;
					end else begin
						phase_d        = PH_HUNT;
						res_valid      = 1'b1;
						res.kind       = K_REJECT;
						res.error_code = E_ESCAPE;
					end
				end else if (rx_byte == ESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					have_d = 1'b1;
				end

				// One byte is always held back: it may turn out to be the check byte.
				if (have_d) begin
					if (!held_valid_q) begin
						held_we      = 1'b1;
						held_valid_d = 1'b1;
					end else if (count_q == CNT_W'(MAX_PAYLOAD)) begin
						phase_d        = PH_HUNT;
						res_valid      = 1'b1;
						res.kind       = K_REJECT;
						res.error_code = E_OVERFLOW;
					end else begin
						held_we           = 1'b1;
						xor_d             = xor_q ^ held_q;
						count_d           = count_inc;
						res_valid         = 1'b1;
						res.kind          = K_DATA;
						res.data_byte     = held_q;
						res.payload_count = count_inc_x[COUNT_W-1:0];
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			hdr_idx_q    <= 2'd0;
			esc_q        <= 1'b0;
			held_valid_q <= 1'b0;
			xor_q        <= '0;
			count_q      <= '0;
			type_q       <= T_INFO;
			seq_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			hdr_idx_q    <= hdr_idx_d;
			esc_q        <= esc_d;
			held_valid_q <= held_valid_d;
			xor_q        <= xor_d;
			count_q      <= count_d;
			type_q       <= type_d;
			seq_q        <= seq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hdr_we) begin
			hdr_q[hdr_idx_q[0]] <= rx_byte;
		end
		if (step && held_we) begin
			held_q <= dval;
		end
	end

endmodule
